// File: src/rgr_pkg.sv
`timescale 1ns / 1ps
// rgr_pkg: shared widths, register indexes and types of the glyph rasterizer
package rgr_pkg;

  localparam int CNT_W   = 8;   // run counts, cursor, glyph dimensions
  localparam int NIB_W   = 4;   // alpha level
  localparam int SCALE_W = 4;
  localparam int ORG_W   = 16;
  localparam int COLOR_W = 24;
  localparam int POS_W   = 17;
  localparam int SIZE_W  = 11;
  localparam int PIX_W   = 32;
  localparam int IDX_W   = 3;
  localparam int DIV_CNT_W = $clog2(CNT_W + 1);

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_ORIGIN_X   = 3'd0;
  localparam logic [IDX_W-1:0] REG_ORIGIN_Y   = 3'd1;
  localparam logic [IDX_W-1:0] REG_RASTER_W   = 3'd2;
  localparam logic [IDX_W-1:0] REG_RASTER_H   = 3'd3;
  localparam logic [IDX_W-1:0] REG_TEXT_COLOR = 3'd4;
  localparam logic [IDX_W-1:0] REG_SCALE      = 3'd5;

  // divider status back to the sequencer
  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] quot;
    logic [CNT_W-1:0] rem;
  } div_res_t;

  // one rectangle in source pixels, before scaling
  typedef struct packed {
    logic [CNT_W-1:0] col;
    logic [CNT_W-1:0] row;
    logic [CNT_W-1:0] w;
    logic [CNT_W-1:0] h;
    logic [NIB_W-1:0] alpha;
  } rect_src_t;

endpackage

// File: src/rgr_ifs.sv
`timescale 1ns / 1ps
// rgr_ifs: handshake channels of the glyph rasterizer (records, rectangles, config)
interface rgr_item_if;
  logic                      valid;
  logic                      ready;
  logic [rgr_pkg::CNT_W-1:0] alpha_pair;
  logic [rgr_pkg::CNT_W-1:0] first_count;
  logic [rgr_pkg::CNT_W-1:0] second_count;
  logic                      glyph_start;
  modport source(output valid, alpha_pair, first_count, second_count, glyph_start,
                 input ready);
  modport sink(input valid, alpha_pair, first_count, second_count, glyph_start,
               output ready);
endinterface

interface rgr_rect_if;
  logic                       valid;
  logic                       ready;
  logic [rgr_pkg::POS_W-1:0]  rect_x;
  logic [rgr_pkg::POS_W-1:0]  rect_y;
  logic [rgr_pkg::SIZE_W-1:0] rect_width;
  logic [rgr_pkg::SIZE_W-1:0] rect_height;
  logic [rgr_pkg::PIX_W-1:0]  pixel_color;
  logic                       last_of_item;
  modport source(output valid, rect_x, rect_y, rect_width, rect_height, pixel_color,
                 last_of_item, input ready);
  modport sink(input valid, rect_x, rect_y, rect_width, rect_height, pixel_color,
               last_of_item, output ready);
endinterface

interface rgr_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [rgr_pkg::IDX_W-1:0]   index;
  logic [rgr_pkg::COLOR_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: src/rgr_div.sv
`timescale 1ns / 1ps
// rgr_div: restoring divider, one quotient bit per cycle
module rgr_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [rgr_pkg::CNT_W-1:0] dividend,
  input  logic [rgr_pkg::CNT_W-1:0] divisor,
  output rgr_pkg::div_res_t         res
);
  import rgr_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [CNT_W-1:0]     quo;
  logic [CNT_W-1:0]     rem;
  logic [CNT_W-1:0]     dsr;
  logic [CNT_W:0]       shifted;
  logic [CNT_W:0]       diff;
  logic                 ge;

  assign shifted = {rem, quo[CNT_W-1]};
  assign ge      = shifted >= {1'b0, dsr};
  assign diff    = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(CNT_W);
      end else if (busy) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
      quo <= {quo[CNT_W-2:0], ge};
    end
  end

  assign res.done = done;
  assign res.quot = quo;
  assign res.rem  = rem;

endmodule

// File: src/rle_glyph_to_rectangles.sv
`timescale 1ns / 1ps
// rle_glyph_to_rectangles: run-length glyph records to scaled filled rectangles
//
// Channels (valid/ready, an item moves when both are high):
//   glyph - one record: two alpha nibbles, two run counts, glyph_start.
//   rect  - one rectangle per item; last_of_item marks the final one of a record.
//   cfg   - register writes (index, data); always ready, write only while idle.
// A record is handled one run after the other by a small sequencer. Each run
// walks: cursor fix-up, leading partial row, a division of the remaining count
// by the glyph width in a shared 8-step restoring divider, the full-row block,
// and the trailing partial row. A run that needs the divider waits in
// S_DIVWAIT until the divider reports done; a skipped run goes on to S_NEXT.
// The glyph channel is ready only in S_IDLE, so the next record is taken only
// after the last one is finished.
// Rectangles are held one deep until the next one (or the end of the record)
// says whether it is the last, so the first one reaches the rect channel only
// once a second one is emitted or the record ends. A second register drives
// the rect channel, so a stalled receiver stalls the sequencer only when both
// are full. Reset (synchronous, active high) clears the cursor, the done
// flag, both rectangle stages, and loads the registers with their defaults.
module rle_glyph_to_rectangles #(
  parameter int MAX_SCALE     = 8,
  parameter int MAX_GLYPH_DIM = 255
) (
  input logic clk,
  input logic rst,
  rgr_item_if.sink glyph,
  rgr_rect_if.source rect,
  rgr_cfg_if.sink cfg
);
  import rgr_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_START   = 4'd1;
  localparam logic [3:0] S_LEAD    = 4'd2;
  localparam logic [3:0] S_DIVGO   = 4'd3;
  localparam logic [3:0] S_DIVWAIT = 4'd4;
  localparam logic [3:0] S_ROWS    = 4'd5;
  localparam logic [3:0] S_TAIL    = 4'd6;
  localparam logic [3:0] S_NEXT    = 4'd7;
  localparam logic [3:0] S_FINISH  = 4'd8;

  localparam logic [SCALE_W:0] SC_MAX  = (SCALE_W+1)'(MAX_SCALE);
  localparam logic [CNT_W-1:0] DIM_MAX = CNT_W'(MAX_GLYPH_DIM);

  // configuration registers
  logic [ORG_W-1:0]   origin_x;
  logic [ORG_W-1:0]   origin_y;
  logic [CNT_W-1:0]   raster_w;
  logic [CNT_W-1:0]   raster_h;
  logic [COLOR_W-1:0] text_color;
  logic [SCALE_W-1:0] scale;

  // sequencer state
  logic [3:0]       state;
  logic [CNT_W-1:0] cursor_col;
  logic [CNT_W-1:0] cursor_row;
  logic             raster_done;
  logic             run_sel;
  logic [CNT_W-1:0] n;
  logic [NIB_W-1:0] alpha;
  logic [CNT_W-1:0] n2;
  logic [NIB_W-1:0] alpha2;

  // rectangle stages
  rect_src_t        pend;
  logic             pend_valid;
  logic             out_valid;
  logic [POS_W-1:0]  out_x;
  logic [POS_W-1:0]  out_y;
  logic [SIZE_W-1:0] out_w;
  logic [SIZE_W-1:0] out_h;
  logic [PIX_W-1:0]  out_color;
  logic              out_last;

  // effective (clamped) settings
  logic [CNT_W-1:0]   w_eff;
  logic [CNT_W-1:0]   h_eff;
  logic [SCALE_W-1:0] sc_eff;

  div_res_t div_res;
  logic     div_start;

  logic [CNT_W-1:0] room;
  logic [CNT_W-1:0] take;
  logic [CNT_W-1:0] lead_end;
  logic [CNT_W-1:0] avail;
  logic [CNT_W-1:0] rows;
  logic [CNT_W:0]   fix_row;
  logic             fix_wrap;
  logic             opaque;
  logic             emit_want;
  logic             emit_ok;
  logic             emit_fire;
  logic             stall;
  logic             out_free;
  logic             fin_move;
  rect_src_t        emit_rect;

  logic [11:0] col_sc;
  logic [11:0] row_sc;
  logic [11:0] w_sc;
  logic [11:0] h_sc;

  assign glyph.ready = (state == S_IDLE);
  assign cfg.ready   = 1'b1;

  always_comb begin
    w_eff = (raster_w > DIM_MAX) ? DIM_MAX : raster_w;
    h_eff = (raster_h > DIM_MAX) ? DIM_MAX : raster_h;
    if (scale == '0) begin
      sc_eff = SCALE_W'(1);
    end else if ({1'b0, scale} > SC_MAX) begin
      sc_eff = SC_MAX[SCALE_W-1:0];
    end else begin
      sc_eff = scale;
    end
  end

  // per-state arithmetic
  always_comb begin
    opaque    = (alpha != '0);
    room      = w_eff - cursor_col;
    take      = (n < room) ? n : room;
    lead_end  = cursor_col + take;
    avail     = h_eff - cursor_row;
    rows      = (div_res.quot > avail) ? avail : div_res.quot;
    fix_wrap  = (cursor_col >= w_eff);
    fix_row   = {1'b0, cursor_row} + {{CNT_W{1'b0}}, fix_wrap};
    emit_want = 1'b0;
    emit_rect = '{col: cursor_col, row: cursor_row, w: take, h: CNT_W'(1), alpha: alpha};
    case (state)
      S_LEAD: begin
        emit_want = opaque && (cursor_col != '0);
      end
      S_ROWS: begin
        emit_want = opaque && (rows != '0);
        emit_rect = '{col: '0, row: cursor_row, w: w_eff, h: rows, alpha: alpha};
      end
      S_TAIL: begin
        emit_want = opaque && !raster_done && (n != '0);
        emit_rect = '{col: '0, row: cursor_row, w: n, h: CNT_W'(1), alpha: alpha};
      end
      default: begin
        emit_want = 1'b0;
      end
    endcase
  end

  assign out_free  = !out_valid || rect.ready;
  assign emit_ok   = !pend_valid || out_free;
  assign emit_fire = emit_want && emit_ok;
  assign stall     = emit_want && !emit_ok;
  assign fin_move  = (state == S_FINISH) && pend_valid && out_free;
  assign div_start = (state == S_DIVGO) && !raster_done && (n != '0);

  rgr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (n),
    .divisor  (w_eff),
    .res      (div_res)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x   <= '0;
      origin_y   <= '0;
      raster_w   <= CNT_W'(8);
      raster_h   <= CNT_W'(16);
      text_color <= '1;
      scale      <= SCALE_W'(1);
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_ORIGIN_X:   origin_x   <= cfg.data[ORG_W-1:0];
        REG_ORIGIN_Y:   origin_y   <= cfg.data[ORG_W-1:0];
        REG_RASTER_W:   raster_w   <= cfg.data[CNT_W-1:0];
        REG_RASTER_H:   raster_h   <= cfg.data[CNT_W-1:0];
        REG_TEXT_COLOR: text_color <= cfg.data;
        REG_SCALE:      scale      <= cfg.data[SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // run sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cursor_col  <= '0;
      cursor_row  <= '0;
      raster_done <= 1'b0;
      run_sel     <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (glyph.valid) begin
            n       <= glyph.first_count;
            alpha   <= glyph.alpha_pair[CNT_W-1:NIB_W];
            n2      <= glyph.second_count;
            alpha2  <= glyph.alpha_pair[NIB_W-1:0];
            run_sel <= 1'b0;
            if (glyph.glyph_start) begin
              cursor_col  <= '0;
              cursor_row  <= '0;
              raster_done <= 1'b0;
            end
            // zero-sized glyph: nothing drawn, cursor not advanced
            if (raster_w == '0 || raster_h == '0) begin
              state <= S_FINISH;
            end else begin
              state <= S_START;
            end
          end
        end
        S_START: begin
          if (raster_done || n == '0) begin
            state <= S_NEXT;
          end else if (fix_row >= {1'b0, h_eff}) begin
            raster_done <= 1'b1;
            cursor_col  <= '0;
            cursor_row  <= fix_row[CNT_W-1:0];
            state       <= S_NEXT;
          end else begin
            if (fix_wrap) begin
              cursor_col <= '0;
              cursor_row <= fix_row[CNT_W-1:0];
            end
            state <= S_LEAD;
          end
        end
        S_LEAD: begin
          if (!stall) begin
            if (cursor_col != '0) begin
              n <= n - take;
              if (lead_end >= w_eff) begin
                cursor_col <= '0;
                cursor_row <= cursor_row + CNT_W'(1);
                if (cursor_row + CNT_W'(1) >= h_eff) begin
                  raster_done <= 1'b1;
                end
              end else begin
                cursor_col <= lead_end;
              end
            end
            state <= S_DIVGO;
          end
        end
        S_DIVGO: begin
          state <= div_start ? S_DIVWAIT : S_TAIL;
        end
        S_DIVWAIT: begin
          if (div_res.done) begin
            state <= S_ROWS;
          end
        end
        S_ROWS: begin
          if (!stall) begin
            n <= div_res.rem;
            if (rows != '0) begin
              cursor_row <= cursor_row + rows;
              if (cursor_row + rows >= h_eff) begin
                raster_done <= 1'b1;
              end
            end
            state <= S_TAIL;
          end
        end
        S_TAIL: begin
          if (!stall) begin
            if (!raster_done && n != '0) begin
              cursor_col <= n;
            end
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (!run_sel) begin
            run_sel <= 1'b1;
            n       <= n2;
            alpha   <= alpha2;
            state   <= S_START;
          end else begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!pend_valid || out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // scaling of the held rectangle on its way to the output register
  assign col_sc = {4'b0, pend.col} * {8'b0, sc_eff};
  assign row_sc = {4'b0, pend.row} * {8'b0, sc_eff};
  assign w_sc   = {4'b0, pend.w} * {8'b0, sc_eff};
  assign h_sc   = {4'b0, pend.h} * {8'b0, sc_eff};

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && rect.ready) begin
        out_valid <= 1'b0;
      end
      if (emit_fire) begin
        pend_valid <= 1'b1;
        if (pend_valid) begin
          out_valid <= 1'b1;
        end
      end else if (fin_move) begin
        pend_valid <= 1'b0;
        out_valid  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      pend <= emit_rect;
    end
    if ((emit_fire && pend_valid) || fin_move) begin
      out_x     <= {1'b0, origin_x} + {5'b0, col_sc};
      out_y     <= {1'b0, origin_y} + {5'b0, row_sc};
      out_w     <= w_sc[SIZE_W-1:0];
      out_h     <= h_sc[SIZE_W-1:0];
      out_color <= {pend.alpha, 4'h0, text_color};
      out_last  <= fin_move;
    end
  end

  assign rect.valid        = out_valid;
  assign rect.rect_x       = out_x;
  assign rect.rect_y       = out_y;
  assign rect.rect_width   = out_w;
  assign rect.rect_height  = out_h;
  assign rect.pixel_color  = out_color;
  assign rect.last_of_item = out_last;

endmodule

// File: tb/rle_glyph_to_rectangles_test.sv
`timescale 1ns / 1ps
// rle_glyph_to_rectangles_test: directed table plus randomized glyph runs, scoreboard-checked
module rle_glyph_to_rectangles_test;
  import rgr_pkg::*;

  localparam int GLYPH_MAX = 255;  // clamp on glyph dimensions
  localparam int ZOOM_MAX  = 8;    // clamp on scale
  localparam int PHASES    = 12;   // random config phases
  localparam int PER_PHASE = 22;   // records per phase that the block acts on
  localparam int SETTLE    = 40;   // wait after the drain, before register writes

  // one glyph record as it goes into the block
  typedef struct packed {
    logic [CNT_W-1:0] alphas;
    logic [CNT_W-1:0] n1;
    logic [CNT_W-1:0] n2;
    logic             start;
  } record_t;

  // one rectangle as it comes out
  typedef struct packed {
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [SIZE_W-1:0] wd;
    logic [SIZE_W-1:0] ht;
    logic [PIX_W-1:0]  color;
    logic              last;
  } rect_t;

  // how a directed row is checked: by the predictor, against one typed-in
  // rectangle, or against no rectangle at all
  typedef enum logic [1:0] {CHECK_MODEL, CHECK_ONE, CHECK_NONE} row_kind_t;

  typedef struct packed {
    record_t   rec;
    row_kind_t kind;
    rect_t     known;
  } dir_row_t;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic clk = 1'b0;
  logic rst;

  rgr_item_if glyph_ch ();
  rgr_rect_if rect_ch ();
  rgr_cfg_if  cfg_ch ();

  rle_glyph_to_rectangles u_top (
    .clk  (clk),
    .rst  (rst),
    .glyph(glyph_ch),
    .rect (rect_ch),
    .cfg  (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: its own copy of the registers and the raster cursor
  // ---------------------------------------------------------------------------
  logic [ORG_W-1:0]   org_x, org_y;
  logic [CNT_W-1:0]   gw, gh;
  logic [COLOR_W-1:0] ink;
  logic [SCALE_W-1:0] zoom;
  logic [CNT_W-1:0]   cur_col, cur_row;
  bit                 finished;

  rect_t batch[$];      // rectangles of the record being predicted
  rect_t rects_due[$];  // rectangles still owed by the block, oldest first

  int errors = 0;
  int tx_gap_pct = 0;    // chance per cycle that the sender holds off
  int rx_stall_pct = 0;  // chance per cycle that the receiver stalls

  function automatic void put_rect(int col, int row, int wd, int ht, int alpha, int sc);
    rect_t r;
    r.x     = POS_W'(org_x + col * sc);
    r.y     = POS_W'(org_y + row * sc);
    r.wd    = SIZE_W'(wd * sc);
    r.ht    = SIZE_W'(ht * sc);
    r.color = {8'(alpha), ink};
    r.last  = 1'b0;
    batch.push_back(r);
  endfunction

  // One run: fix the cursor if it sits past the row end, then the leading
  // partial row, the full-row block and the trailing partial row.
  function automatic void walk_run(int n, int alpha, int w, int h, int sc);
    int c, r, take, rows;
    bit opaque;
    c = cur_col;
    r = cur_row;
    opaque = (alpha != 0);
    if (finished || n == 0) return;
    if (c >= w) begin
      c = 0;
      r++;
    end
    if (r >= h) begin
      finished = 1'b1;
      cur_col = '0;
      cur_row = CNT_W'(r);
      return;
    end
    if (c > 0) begin
      take = (n < w - c) ? n : w - c;
      if (opaque) put_rect(c, r, take, 1, alpha, sc);
      c += take;
      n -= take;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) finished = 1'b1;
      end
    end
    if (!finished && n > 0) begin
      rows = n / w;
      if (rows > h - r) rows = h - r;
      if (rows > 0) begin
        if (opaque) put_rect(0, r, w, rows, alpha, sc);
        r += rows;
        n -= rows * w;
        if (r >= h) finished = 1'b1;
      end
    end
    if (!finished && n > 0) begin
      if (opaque) put_rect(0, r, n, 1, alpha, sc);
      c = n;
    end
    cur_col = CNT_W'(c);
    cur_row = CNT_W'(r);
  endfunction

  // Fills batch with the rectangles one record causes.
  function automatic void rasterize(record_t rec);
    int w, h, sc;
    w = gw;
    h = gh;
    sc = zoom;
    batch.delete();
    if (rec.start) begin
      cur_col = '0;
      cur_row = '0;
      finished = 1'b0;
    end
    if (w == 0 || h == 0) return;
    if (w > GLYPH_MAX) w = GLYPH_MAX;
    if (h > GLYPH_MAX) h = GLYPH_MAX;
    if (sc == 0) sc = 1;
    if (sc > ZOOM_MAX) sc = ZOOM_MAX;
    walk_run(rec.n1, int'(rec.alphas[7:4]) * 16, w, h, sc);
    walk_run(rec.n2, int'(rec.alphas[3:0]) * 16, w, h, sc);
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table, run right after reset with the register defaults
  // (8 x 16 raster, scale 1, origin 0, white). Typed-in rows are the ones
  // that can be read off directly; the rest go through the predictor.
  // ---------------------------------------------------------------------------
  dir_row_t directed [18] = '{
    // one full row from the top-left, opaque max alpha
    '{'{8'hF0, 8'd8, 8'd0, 1'b1}, CHECK_ONE,
      '{17'd0, 17'd0, 11'd8, 11'd1, 32'hF0FF_FFFF, 1'b1}},
    // transparent run moves the cursor, then a leading partial row
    '{'{8'h0F, 8'd3, 8'd2, 1'b0}, CHECK_ONE,
      '{17'd3, 17'd1, 11'd2, 11'd1, 32'hF0FF_FFFF, 1'b1}},
    '{'{8'h11, 8'd5, 8'd13, 1'b0}, CHECK_MODEL, '0},
    // zero counts: nothing
    '{'{8'h88, 8'd0, 8'd0, 1'b0}, CHECK_NONE, '0},
    // transparent runs to the end of the raster
    '{'{8'h00, 8'd255, 8'd255, 1'b0}, CHECK_NONE, '0},
    // raster finished: record ignored
    '{'{8'hFF, 8'd10, 8'd10, 1'b0}, CHECK_NONE, '0},
    // max counts: whole raster in one block, second run dropped
    '{'{8'hFF, 8'd255, 8'd255, 1'b1}, CHECK_ONE,
      '{17'd0, 17'd0, 11'd8, 11'd16, 32'hF0FF_FFFF, 1'b1}},
    '{'{8'hA5, 8'd3, 8'd20, 1'b1}, CHECK_MODEL, '0},
    '{'{8'h5A, 8'd19, 8'd23, 1'b0}, CHECK_MODEL, '0},
    // six rectangles from one record
    '{'{8'h7C, 8'd18, 8'd15, 1'b0}, CHECK_MODEL, '0},
    // lowest opaque alpha, single pixel
    '{'{8'h10, 8'd1, 8'd0, 1'b0}, CHECK_MODEL, '0},
    // long run passes the last row, rest dropped
    '{'{8'h01, 8'd0, 8'd255, 1'b0}, CHECK_MODEL, '0},
    '{'{8'hF0, 8'd1, 8'd0, 1'b0}, CHECK_NONE, '0},
    '{'{8'h0F, 8'd255, 8'd0, 1'b1}, CHECK_NONE, '0},
    '{'{8'hE7, 8'd0, 8'd1, 1'b1}, CHECK_ONE,
      '{17'd0, 17'd0, 11'd1, 11'd1, 32'h70FF_FFFF, 1'b1}},
    '{'{8'h3C, 8'd8, 8'd128, 1'b0}, CHECK_MODEL, '0},
    '{'{8'h99, 8'd255, 8'd255, 1'b1}, CHECK_ONE,
      '{17'd0, 17'd0, 11'd8, 11'd16, 32'h90FF_FFFF, 1'b1}},
    '{'{8'h00, 8'd0, 8'd0, 1'b1}, CHECK_NONE, '0}
  };

  // ---------------------------------------------------------------------------
  // Driving: everything changes at the falling edge; handshakes are judged
  // at the rising edge. Tasks are entered and left just after a falling edge.
  // ---------------------------------------------------------------------------
  task automatic send_record(input record_t rec, input row_kind_t kind, input rect_t known,
                             output bit ignored);
    while ($urandom_range(99) < tx_gap_pct) begin
      glyph_ch.valid = 1'b0;
      @(negedge clk);
    end
    glyph_ch.valid        = 1'b1;
    glyph_ch.alpha_pair   = rec.alphas;
    glyph_ch.first_count  = rec.n1;
    glyph_ch.second_count = rec.n2;
    glyph_ch.glyph_start  = rec.start;
    @(posedge clk);
    while (!glyph_ch.ready) @(posedge clk);
    // taken at this edge
    ignored = (gw == 0 || gh == 0 || (finished && !rec.start));
    rasterize(rec);
    case (kind)
      CHECK_MODEL: foreach (batch[i]) rects_due.push_back(batch[i]);
      CHECK_ONE:   rects_due.push_back(known);
      default:     ;
    endcase
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [COLOR_W-1:0] value);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_ORIGIN_X:   org_x = value[ORG_W-1:0];
      REG_ORIGIN_Y:   org_y = value[ORG_W-1:0];
      REG_RASTER_W:   gw    = value[CNT_W-1:0];
      REG_RASTER_H:   gh    = value[CNT_W-1:0];
      REG_TEXT_COLOR: ink   = value;
      REG_SCALE:      zoom  = value[SCALE_W-1:0];
      default:        ;
    endcase
    @(negedge clk);
  endtask

  // wait for the block to go quiet before touching its registers
  task automatic settle();
    glyph_ch.valid = 1'b0;
    while (rects_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Register settings per phase: the extremes first, then zero glyph sizes,
  // out-of-range scales and a width shrink that can strand the cursor past
  // the row end; later phases rewrite a random subset, with junk in the
  // data bits above each register's width.
  task automatic configure_phase(int p);
    case (p)
      0: begin
        write_reg(REG_ORIGIN_X, 24'd0);
        write_reg(REG_ORIGIN_Y, 24'd0);
        write_reg(REG_RASTER_W, 24'd8);
        write_reg(REG_RASTER_H, 24'd16);
        write_reg(REG_TEXT_COLOR, 24'hFF_FFFF);
        write_reg(REG_SCALE, 24'd1);
      end
      1: begin
        write_reg(REG_ORIGIN_X, 24'h00_FFFF);
        write_reg(REG_ORIGIN_Y, 24'h00_FFFF);
        write_reg(REG_RASTER_W, 24'd255);
        write_reg(REG_RASTER_H, 24'd255);
        write_reg(REG_TEXT_COLOR, 24'd0);
        write_reg(REG_SCALE, 24'd8);
      end
      2: begin
        write_reg(REG_ORIGIN_X, 24'($urandom));
        write_reg(REG_ORIGIN_Y, 24'($urandom));
        write_reg(REG_RASTER_W, 24'd1);
        write_reg(REG_RASTER_H, 24'd1);
        write_reg(REG_TEXT_COLOR, 24'($urandom));
        write_reg(REG_SCALE, 24'd15);
      end
      3: write_reg(REG_RASTER_W, 24'd0);
      4: begin
        write_reg(REG_RASTER_W, 24'd12);
        write_reg(REG_RASTER_H, 24'd0);
      end
      5: begin
        write_reg(REG_RASTER_W, 24'd20);
        write_reg(REG_RASTER_H, 24'd9);
        write_reg(REG_SCALE, 24'd0);
      end
      6: write_reg(REG_RASTER_W, 24'd3);
      default: begin
        if ($urandom_range(1)) write_reg(REG_ORIGIN_X, 24'($urandom));
        if ($urandom_range(1)) write_reg(REG_ORIGIN_Y, 24'($urandom));
        if ($urandom_range(1))
          write_reg(REG_RASTER_W, {16'($urandom), 8'($urandom_range(40, 1))});
        if ($urandom_range(1))
          write_reg(REG_RASTER_H, {16'($urandom), 8'($urandom_range(40, 1))});
        if ($urandom_range(1)) write_reg(REG_TEXT_COLOR, 24'($urandom));
        write_reg(REG_SCALE, {20'($urandom), 4'($urandom_range(15))});
      end
    endcase
    cfg_ch.valid = 1'b0;
  endtask

  function automatic void set_idle(idle_mode_t m);
    case (m)
      IDLE_NONE:     begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
      IDLE_SENDER:   begin tx_gap_pct = 80; rx_stall_pct = 0;  end
      IDLE_RECEIVER: begin tx_gap_pct = 0;  rx_stall_pct = 80; end
      default:       begin tx_gap_pct = 24; rx_stall_pct = 24; end
    endcase
  endfunction

  // run counts: mostly around a couple of rows so all three rectangle kinds
  // show up, with zero and full-range counts mixed in
  function automatic logic [CNT_W-1:0] draw_count();
    int span, roll;
    span = (gw == 0) ? 16 : 2 * gw + 2;
    if (span > 255) span = 255;
    roll = $urandom_range(99);
    if (roll < 8) return '0;
    if (roll < 18) return CNT_W'($urandom_range(255));
    return CNT_W'($urandom_range(span));
  endfunction

  // Well-formed glyphs most of the time: a start, then records until the
  // raster fills. Now and then a restart mid-glyph, or records sent into a
  // finished raster as noise.
  function automatic record_t make_record();
    record_t r;
    r.start  = finished ? ($urandom_range(99) < 85) : ($urandom_range(99) < 5);
    r.alphas = {($urandom_range(3) == 0) ? 4'h0 : 4'($urandom_range(15, 1)),
                ($urandom_range(3) == 0) ? 4'h0 : 4'($urandom_range(15, 1))};
    r.n1     = draw_count();
    r.n2     = draw_count();
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: ready toggles at the falling edge per the current stall rate
  // ---------------------------------------------------------------------------
  initial begin
    rect_ch.ready = 1'b0;
    forever @(negedge clk) rect_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  function automatic void match(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  // Scoreboard: every accepted rectangle against the oldest one owed.
  always @(posedge clk) begin : check_rect
    rect_t got, want;
    if (!rst && rect_ch.valid && rect_ch.ready) begin
      got = '{rect_ch.rect_x, rect_ch.rect_y, rect_ch.rect_width, rect_ch.rect_height,
              rect_ch.pixel_color, rect_ch.last_of_item};
      if (rects_due.size() == 0) begin
        $error("rectangle with none owed: x=%0d y=%0d w=%0d h=%0d",
               got.x, got.y, got.wd, got.ht);
        errors++;
      end else begin
        want = rects_due.pop_front();
        match("rect_x", 32'(want.x), 32'(got.x));
        match("rect_y", 32'(want.y), 32'(got.y));
        match("rect_width", 32'(want.wd), 32'(got.wd));
        match("rect_height", 32'(want.ht), 32'(got.ht));
        match("pixel_color", want.color, got.color);
        match("last_of_item", 32'(want.last), 32'(got.last));
      end
    end
  end

  // hard stop well past the slowest legal run
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    record_t rec;
    bit ignored;
    int counted, sent, cap;

    rst = 1'b1;
    glyph_ch.valid        = 1'b0;
    glyph_ch.alpha_pair   = '0;
    glyph_ch.first_count  = '0;
    glyph_ch.second_count = '0;
    glyph_ch.glyph_start  = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;

    // predictor mirrors the reset state
    org_x = '0;
    org_y = '0;
    gw = 8'd8;
    gh = 8'd16;
    ink = 24'hFF_FFFF;
    zoom = 4'd1;
    cur_col = '0;
    cur_row = '0;
    finished = 1'b0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    set_idle(IDLE_NONE);
    foreach (directed[i])
      send_record(directed[i].rec, directed[i].kind, directed[i].known, ignored);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      configure_phase(p);
      set_idle(idle_mode_t'(p % 4));
      // a zero-size raster ignores everything: a handful of records is enough
      cap = (gw == 0 || gh == 0) ? 6 : 400;
      counted = 0;
      sent = 0;
      while (counted < PER_PHASE && sent < cap) begin
        rec = make_record();
        send_record(rec, CHECK_MODEL, '0, ignored);
        sent++;
        if (!ignored) counted++;
      end
      glyph_ch.valid = 1'b0;
    end

    // drain, then give the block time to show any stray rectangle
    while (rects_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
